@@ rtl/hsv_to_rgb_converter_top_macros.svh @@
// assertion macros for the hsv to rgb converter top
`ifndef HSV_TO_RGB_CONVERTER_TOP_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define H2R_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define H2R_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/h2r_pkg.sv @@
// shared constants for the hsv to rgb converter
package h2r_pkg;

   // register index port width and register map
   localparam int CSR_INDEX_BITS = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SATURATION = 2'd0,
      CSR_BRIGHTNESS = 2'd1
   } csr_index_type;

   // reset values before masking to the color width
   localparam int SAT_RESET_VALUE    = 230;
   localparam int BRIGHT_RESET_VALUE = 255;

endpackage

@@ rtl/h2r_csr.sv @@
// saturation and brightness configuration registers
module h2r_csr #(
   parameter int COLOR_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [h2r_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [COLOR_BITS-1:0]               csr_data,
   output logic [COLOR_BITS-1:0]               saturation,
   output logic [COLOR_BITS-1:0]               brightness
);
   import h2r_pkg::*;

   localparam int CMAX = (1 << COLOR_BITS) - 1;
   localparam logic [COLOR_BITS-1:0] SAT_RESET    = COLOR_BITS'(SAT_RESET_VALUE & CMAX);
   localparam logic [COLOR_BITS-1:0] BRIGHT_RESET = COLOR_BITS'(BRIGHT_RESET_VALUE & CMAX);

   logic [COLOR_BITS-1:0] sat_ff;
   logic [COLOR_BITS-1:0] sat_in;
   logic [COLOR_BITS-1:0] bright_ff;
   logic [COLOR_BITS-1:0] bright_in;

   assign csr_ready = 1'b1;

   // writes beyond the register map are dropped
   always_comb begin
      sat_in    = sat_ff;
      bright_in = bright_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SATURATION: sat_in    = csr_data;
            CSR_BRIGHTNESS: bright_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sat_ff    <= SAT_RESET;
         bright_ff <= BRIGHT_RESET;
      end else begin
         sat_ff    <= sat_in;
         bright_ff <= bright_in;
      end
   end

   assign saturation = sat_ff;
   assign brightness = bright_ff;

endmodule

@@ rtl/hsv_to_rgb_converter_top.sv @@
// an accepted req transaction passes through stage registers 1 to 4 before rsp_tvalid
// throughput: one hue per cycle while rsp_tready does not stall; a four stage pipeline with a valid bit per stage
// stall: ready ripples back from rsp_tready, bubbles are squeezed out
// reset: clears all stage valid bits, loads saturation 230 and brightness 255
// config written while the pipeline is empty applies to all later hues
`include "hsv_to_rgb_converter_top_macros.svh"

module hsv_to_rgb_converter_top #(
   parameter int HUE_BITS   = 16,
   parameter int COLOR_BITS = 8
) (
   input  logic                                        clock,
   input  logic                                        reset,
   // req_tdata: hue
   input  logic                                        req_tvalid,
   output logic                                        req_tready,
   input  logic [((HUE_BITS+7)/8)*8-1:0]               req_tdata,
   // rsp_tdata: red, green, blue
   output logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   output logic [((3*COLOR_BITS+7)/8)*8-1:0]           rsp_tdata,
   input  logic                                        csr_valid,
   output logic                                        csr_ready,
   input  logic [h2r_pkg::CSR_INDEX_BITS-1:0]          csr_index,
   input  logic [COLOR_BITS-1:0]                       csr_data
);
   import h2r_pkg::*;

   localparam int C     = COLOR_BITS;
   localparam int H     = HUE_BITS;
   localparam int RSP_W = ((3*COLOR_BITS+7)/8)*8;
   localparam int H6_W  = H + 3;
   localparam int ZQ_W  = 2*C + H;
   localparam int ZT_W  = 2*C + H + 1;
   localparam int Y_W   = 2*C + H + 1;
   localparam logic [C-1:0] CMAX = {C{1'b1}};
   localparam logic [H:0]   HONE = {1'b1, {H{1'b0}}};

   typedef enum logic [2:0] {
      SEC_RED_YEL = 3'd0,
      SEC_YEL_GRN = 3'd1,
      SEC_GRN_CYN = 3'd2,
      SEC_CYN_BLU = 3'd3,
      SEC_BLU_MAG = 3'd4,
      SEC_MAG_RED = 3'd5
   } sector_type;

   // floor(x / CMAX), exact for x up to CMAX*CMAX
   function automatic logic [C-1:0] div_cmax(input logic [2*C-1:0] x);
      logic [2*C:0] sum;
      sum = {1'b0, x} + {{(C+1){1'b0}}, x[2*C-1:C]} + {{(2*C){1'b0}}, 1'b1};
      return sum[2*C-1:C];
   endfunction

   logic [C-1:0] sat;
   logic [C-1:0] bright;

   h2r_csr #(
      .COLOR_BITS(COLOR_BITS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .saturation(sat),
      .brightness(bright)
   );

   // stage handshake
   logic vld1_ff, vld2_ff, vld3_ff, vld4_ff;
   logic rdy1, rdy2, rdy3, rdy4;

   assign rdy4 = !vld4_ff || rsp_tready;
   assign rdy3 = !vld3_ff || rdy4;
   assign rdy2 = !vld2_ff || rdy3;
   assign rdy1 = !vld1_ff || rdy2;
   assign req_tready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
      end else begin
         if (rdy1) vld1_ff <= req_tvalid;
         if (rdy2) vld2_ff <= vld1_ff;
         if (rdy3) vld3_ff <= vld2_ff;
         if (rdy4) vld4_ff <= vld3_ff;
      end
   end

   // stage 1: sector split and config products
   logic [H-1:0]    hue;
   logic [H6_W-1:0] h6;
   sector_type      sec1_in, sec1_ff;
   logic [H-1:0]    frac1_in, frac1_ff;
   logic [2*C-1:0]  vs1_in, vs1_ff;
   logic [2*C-1:0]  pn1_in, pn1_ff;
   logic [C-1:0]    v1_ff;

   assign hue      = req_tdata[H-1:0];
   assign h6       = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};
   assign sec1_in  = sector_type'(h6[H6_W-1:H]);
   assign frac1_in = h6[H-1:0];
   assign vs1_in   = (2*C)'(bright) * (2*C)'(sat);
   assign pn1_in   = (2*C)'(bright) * (2*C)'(CMAX - sat);

   always_ff @(posedge clock) begin
      if (rdy1) begin
         sec1_ff  <= sec1_in;
         frac1_ff <= frac1_in;
         vs1_ff   <= vs1_in;
         pn1_ff   <= pn1_in;
         v1_ff    <= bright;
      end
   end

   // stage 2: saturation times fraction, p finished
   logic [ZQ_W-1:0] zq2_in, zq2_ff;
   logic [ZT_W-1:0] zt2_in, zt2_ff;
   logic [C-1:0]    p2_in, p2_ff;
   logic [C-1:0]    v2_ff;
   sector_type      sec2_ff;

   assign zq2_in = ZQ_W'(vs1_ff) * ZQ_W'(frac1_ff);
   assign zt2_in = ZT_W'(vs1_ff) * ZT_W'(HONE - {1'b0, frac1_ff});
   assign p2_in  = div_cmax(pn1_ff);

   always_ff @(posedge clock) begin
      if (rdy2) begin
         zq2_ff  <= zq2_in;
         zt2_ff  <= zt2_in;
         p2_ff   <= p2_in;
         v2_ff   <= v1_ff;
         sec2_ff <= sec1_ff;
      end
   end

   // stage 3: v*CMAX*HONE minus the products, scaled down by HONE
   logic [2*C-1:0] vc2;
   logic [Y_W-1:0] yq2, yt2;
   logic [2*C-1:0] wq3_ff, wt3_ff;
   logic [C-1:0]   p3_ff;
   logic [C-1:0]   v3_ff;
   sector_type     sec3_ff;

   assign vc2 = {v2_ff, {C{1'b0}}} - (2*C)'(v2_ff);
   assign yq2 = {1'b0, vc2, {H{1'b0}}} - Y_W'(zq2_ff);
   assign yt2 = {1'b0, vc2, {H{1'b0}}} - Y_W'(zt2_ff);

   always_ff @(posedge clock) begin
      if (rdy3) begin
         wq3_ff  <= yq2[2*C+H-1:H];
         wt3_ff  <= yt2[2*C+H-1:H];
         p3_ff   <= p2_ff;
         v3_ff   <= v2_ff;
         sec3_ff <= sec2_ff;
      end
   end

   // stage 4: q and t, sector routing into the output register
   logic [C-1:0] q3, t3;
   logic [C-1:0] red_in, green_in, blue_in;
   logic [C-1:0] red_ff, green_ff, blue_ff;
   logic [C-1:0] v4_ff;

   assign q3 = div_cmax(wq3_ff);
   assign t3 = div_cmax(wt3_ff);

   always_comb begin
      case (sec3_ff)
         SEC_RED_YEL: begin red_in = v3_ff; green_in = t3;    blue_in = p3_ff; end
         SEC_YEL_GRN: begin red_in = q3;    green_in = v3_ff; blue_in = p3_ff; end
         SEC_GRN_CYN: begin red_in = p3_ff; green_in = v3_ff; blue_in = t3;    end
         SEC_CYN_BLU: begin red_in = p3_ff; green_in = q3;    blue_in = v3_ff; end
         SEC_BLU_MAG: begin red_in = t3;    green_in = p3_ff; blue_in = v3_ff; end
         default:     begin red_in = v3_ff; green_in = p3_ff; blue_in = q3;    end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
         v4_ff    <= v3_ff;
      end
   end

   assign rsp_tvalid = vld4_ff;
   assign rsp_tdata  = RSP_W'({blue_ff, green_ff, red_ff});

   // the brightness always lands on one channel
   `H2R_ASSERT_IMPLY(a_max_is_bright, clock, reset, vld4_ff, (red_ff == v4_ff) || (green_ff == v4_ff) || (blue_ff == v4_ff), "no channel carries the brightness")
   // an empty output stage means the whole pipe can take a transaction
   `H2R_ASSERT_IMPLY(a_idle_ready, clock, reset, !vld4_ff, req_tready, "req_tready low with empty output stage")
   // a valid stage 3 moves into the output register when it has room
   `H2R_ASSERT_NEXT(a_advance, clock, reset, vld3_ff && rdy4, vld4_ff, "stage 3 transaction lost")

endmodule

@@ test/tb_top.sv @@
// self-checking testbench for the hsv to rgb converter: hue stream in, packed rgb out
`timescale 1ns / 100ps

module tb_top;
   import h2r_pkg::*;

   localparam int HUE_BITS   = 16;
   localparam int COLOR_BITS = 8;
   localparam int REQ_WIDTH  = ((HUE_BITS + 7) / 8) * 8;
   localparam int RSP_WIDTH  = ((3 * COLOR_BITS + 7) / 8) * 8;

   localparam longint unsigned HUE_ONE   = 64'd1 << HUE_BITS;
   localparam longint unsigned COLOR_MAX = (64'd1 << COLOR_BITS) - 64'd1;
   localparam longint unsigned FULL_SCALE = COLOR_MAX * HUE_ONE;

   // indexes past the register map, writes there must be dropped
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED_LO = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED_HI = 2'd3;

   localparam int PIPE_LATENCY  = 4;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int REPORT_LIMIT  = 10;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS   = 93;

   // red sits in the low byte of rsp_tdata
   typedef struct packed {
      logic [COLOR_BITS-1:0] blue;
      logic [COLOR_BITS-1:0] green;
      logic [COLOR_BITS-1:0] red;
   } rgb_type;

   class rgb_scoreboard;
      logic [COLOR_BITS-1:0] sat_reg    = COLOR_BITS'(SAT_RESET_VALUE);
      logic [COLOR_BITS-1:0] bright_reg = COLOR_BITS'(BRIGHT_RESET_VALUE);
      rgb_type color_q[$];
      int unsigned failures = 0;

      function void set_register(logic [CSR_INDEX_BITS-1:0] index,
                                 logic [COLOR_BITS-1:0] value);
         case (index)
            CSR_SATURATION: sat_reg = value;
            CSR_BRIGHTNESS: bright_reg = value;
            default: ;
         endcase
      endfunction

      function rgb_type convert_hue(logic [HUE_BITS-1:0] hue);
         longint unsigned h6, sector, frac, v, s, p, q, t;
         logic [COLOR_BITS-1:0] vc, pc, qc, tc;
         rgb_type res;
         h6     = longint'(hue) * 6;
         sector = h6 >> HUE_BITS;
         frac   = h6 & (HUE_ONE - 1);
         v      = longint'(bright_reg);
         s      = longint'(sat_reg);
         p = v * (COLOR_MAX - s) / COLOR_MAX;
         q = v * (FULL_SCALE - s * frac) / FULL_SCALE;
         t = v * (FULL_SCALE - s * (HUE_ONE - frac)) / FULL_SCALE;
         vc = COLOR_BITS'(v);
         pc = COLOR_BITS'(p);
         qc = COLOR_BITS'(q);
         tc = COLOR_BITS'(t);
         case (sector)
            64'd0: begin res.red = vc; res.green = tc; res.blue = pc; end
            64'd1: begin res.red = qc; res.green = vc; res.blue = pc; end
            64'd2: begin res.red = pc; res.green = vc; res.blue = tc; end
            64'd3: begin res.red = pc; res.green = qc; res.blue = vc; end
            64'd4: begin res.red = tc; res.green = pc; res.blue = vc; end
            default: begin res.red = vc; res.green = pc; res.blue = qc; end
         endcase
         return res;
      endfunction

      function void note_hue(logic [HUE_BITS-1:0] hue);
         color_q.push_back(convert_hue(hue));
      endfunction

      function void check_rgb(logic [3*COLOR_BITS-1:0] data);
         rgb_type got;
         rgb_type want;
         got = data;
         if (color_q.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("unexpected rsp transaction: r=%0d g=%0d b=%0d",
                        got.red, got.green, got.blue);
            return;
         end
         want = color_q.pop_front();
         if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("rgb mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                        want.red, want.green, want.blue, got.red, got.green, got.blue);
         end
      endfunction

      function int pending();
         return color_q.size();
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_tvalid;
   logic                          req_tready;
   logic [REQ_WIDTH-1:0]          req_tdata;
   logic                          rsp_tvalid;
   logic                          rsp_tready;
   logic [RSP_WIDTH-1:0]          rsp_tdata;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [CSR_INDEX_BITS-1:0]     csr_index;
   logic [COLOR_BITS-1:0]         csr_data;

   rgb_scoreboard sb;
   bit            gap_on;
   bit            stall_on;
   int unsigned   cycle_count = 0;

   hsv_to_rgb_converter_top #(
      .HUE_BITS   (HUE_BITS),
      .COLOR_BITS (COLOR_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // transactions are taken at the rising edge, before the dut updates
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end else if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_hue(req_tdata[HUE_BITS-1:0]);
         if (rsp_tvalid && rsp_tready)
            sb.check_rgb(rsp_tdata[3*COLOR_BITS-1:0]);
         if (csr_valid && csr_ready)
            sb.set_register(csr_index, csr_data);
      end
   end

   // receiver side back-pressure
   initial begin
      rsp_tready = 1'b0;
      forever begin
         if (stall_on && $urandom_range(0, 5) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end else begin
            rsp_tready = 1'b1;
            repeat ($urandom_range(1, 24)) @(negedge clock);
         end
      end
   end

   // all drive tasks start and end at a falling edge
   task automatic send_hue(input logic [HUE_BITS-1:0] hue);
      if (gap_on && $urandom_range(0, 7) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = hue;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drive_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [COLOR_BITS-1:0] value);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // drain the pipeline so register writes land while it is empty
   task automatic drain_pipeline();
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (PIPE_LATENCY + 2) @(negedge clock);
   endtask

   function automatic logic [HUE_BITS-1:0] pick_hue();
      int unsigned sel;
      int          boundary;
      sel = $urandom_range(0, 9);
      if (sel < 7)
         return HUE_BITS'($urandom_range(0, 65535));
      if (sel < 9) begin
         // land near a sector crossing
         boundary = (int'($urandom_range(0, 5)) * 65536 + 5) / 6;
         return HUE_BITS'(boundary + int'($urandom_range(0, 4)) - 2);
      end
      return ($urandom_range(0, 1) != 0) ? {HUE_BITS{1'b1}} : {HUE_BITS{1'b0}};
   endfunction

   logic [HUE_BITS-1:0] corner_hues[16] = '{
      16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h5555, 16'hAAAA,
      16'd10922, 16'd10923, 16'd21845, 16'd21846, 16'd32767, 16'd32768,
      16'd43690, 16'd43691, 16'd54612, 16'd54613
   };

   initial begin
      logic [COLOR_BITS-1:0] sat_val;
      logic [COLOR_BITS-1:0] bright_val;
      sb         = new;
      gap_on     = 1'b0;
      stall_on   = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = CSR_SATURATION;
      csr_data   = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset register values, all corners of the hue range
      foreach (corner_hues[i])
         send_hue(corner_hues[i]);
      drain_pipeline();

      // out-of-map writes must not disturb the registers
      drive_register(CSR_UNMAPPED_LO, 8'h00);
      drive_register(CSR_UNMAPPED_HI, 8'h11);
      // zero saturation gives gray at the brightness level
      drive_register(CSR_SATURATION, 8'd0);
      drive_register(CSR_BRIGHTNESS, 8'd200);
      send_hue(16'h0000);
      send_hue(16'd21846);
      send_hue(16'd43691);
      send_hue(16'hFFFF);
      drain_pipeline();
      drive_register(CSR_SATURATION, 8'd255);
      drive_register(CSR_BRIGHTNESS, 8'd255);
      send_hue(16'd5461);
      send_hue(16'd27306);
      send_hue(16'd49151);
      send_hue(16'hFFFF);
      drain_pipeline();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin sat_val = 8'd0;   bright_val = 8'd0;   end
            1: begin sat_val = 8'd255; bright_val = 8'd0;   end
            2: begin sat_val = 8'd0;   bright_val = 8'd255; end
            3: begin sat_val = 8'd255; bright_val = 8'd255; end
            4: begin sat_val = 8'd1;   bright_val = 8'd254; end
            default: begin
               sat_val    = COLOR_BITS'($urandom_range(0, 255));
               bright_val = COLOR_BITS'($urandom_range(0, 255));
            end
         endcase
         if ($urandom_range(0, 2) == 0)
            drive_register(($urandom_range(0, 1) != 0) ? CSR_UNMAPPED_HI : CSR_UNMAPPED_LO,
                           COLOR_BITS'($urandom));
         if ($urandom_range(0, 1) != 0) begin
            drive_register(CSR_SATURATION, sat_val);
            drive_register(CSR_BRIGHTNESS, bright_val);
         end else begin
            drive_register(CSR_BRIGHTNESS, bright_val);
            drive_register(CSR_SATURATION, sat_val);
         end
         // final phase runs at full rate with no idling
         gap_on   = (phase != RANDOM_PHASES - 1) && (phase % 3 != 1);
         stall_on = (phase != RANDOM_PHASES - 1) && (phase % 4 != 2);
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_hue(pick_hue());
         drain_pipeline();
      end

      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (PIPE_LATENCY * 3) @(posedge clock);
      if (sb.failures == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
